FILE: rtl/tccl_pkg.sv
// Types, codes and the remote command table shared by the code lock files.
package tccl_pkg;

  typedef enum logic [3:0] {
    EV_NONE        = 4'd0,
    EV_DIGIT       = 4'd1,
    EV_CLEARED     = 4'd2,
    EV_SAVED       = 4'd3,
    EV_TOO_FEW     = 4'd4,
    EV_FULL        = 4'd5,
    EV_LOCKED_IGN  = 4'd6,
    EV_REPEAT      = 4'd7,
    EV_UNKNOWN_IR  = 4'd8,
    EV_UNLOCKED    = 4'd9,
    EV_WRONG       = 4'd10
  } event_e;

  typedef enum logic [1:0] {
    MODE_WAITING  = 2'd0,
    MODE_LOCKED   = 2'd1,
    MODE_UNLOCKED = 2'd2
  } mode_e;

  localparam logic [7:0] KEY_NONE  = 8'h00;
  localparam logic [7:0] KEY_STAR  = 8'h2A;
  localparam logic [7:0] KEY_HASH  = 8'h23;
  localparam logic [7:0] KEY_ZERO  = 8'h30;
  localparam logic [7:0] KEY_NINE  = 8'h39;

  localparam int unsigned RemoteKeys = 10;
  localparam logic [7:0] REMOTE_TABLE [RemoteKeys] = '{
    8'h16, 8'h0C, 8'h18, 8'h5E, 8'h08, 8'h1C, 8'h5A, 8'h42, 8'h52, 8'h4A
  };

  typedef logic [3:0] digit_t;

  typedef struct packed {
    logic       cmd;
    logic [7:0] key_code;
    logic       is_repeat;
  } item_t;

  typedef struct packed {
    event_e     event_res;
    mode_e      mode;
    logic [2:0] digits_entered;
  } result_t;

  typedef struct packed {
    logic   hit;
    digit_t digit;
  } lookup_t;

  // Maps a remote command byte to its digit; hit is low for unknown bytes.
  function automatic lookup_t remote_lookup(input logic [7:0] code);
    lookup_t res;
    res = '0;
    for (int i = 0; i < RemoteKeys; i++) begin
      if (REMOTE_TABLE[i] == code) begin
        res.hit   = 1'b1;
        res.digit = 4'(i);
      end
    end
    return res;
  endfunction

endpackage

FILE: rtl/tccl_if.sv
// Valid/ready channel interfaces for the code lock input and result streams.
interface tccl_in_if;
  logic       valid;
  logic       ready;
  logic       cmd;
  logic [7:0] key_code;
  logic       is_repeat;

  modport source (output valid, cmd, key_code, is_repeat, input ready);
  modport sink (input valid, cmd, key_code, is_repeat, output ready);
endinterface

interface tccl_out_if;
  logic       valid;
  logic       ready;
  logic [3:0] event_res;
  logic [1:0] mode;
  logic [2:0] digits_entered;

  modport source (output valid, event_res, mode, digits_entered, input ready);
  modport sink (input valid, event_res, mode, digits_entered, output ready);
endinterface

FILE: rtl/two_channel_code_lock.sv
// Code lock top level: input stage, step engine and result register.
//
// Usage: items arrive on in_i, each a keypad character (cmd low) or an IR
// remote command byte with its repeat flag (cmd high). Every item yields
// exactly one result on out_o: an event code, the mode after the step and
// the digit count of the buffer that the item addressed.
// Path: an item accepted on in_i sits in the input register, is stepped
// once the result register is free and is presented on out_o from there.
// Throughput: one item per cycle while out_o.ready is high. The step
// logic is a single pass over the lock state, with the code compare
// done on all digits in parallel.
// Reset: the lock waits for a code, both digit counts are zero and both
// pipeline registers are empty. Digit stores hold no reset value; only
// entries that were written are ever read.
// Stall: while out_o.ready is low the result register holds its transfer;
// the input register still takes one more item, and in_i.ready falls once
// both registers are occupied.
module two_channel_code_lock #(
  parameter int unsigned CODE_DIGITS = 4
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  tccl_in_if.sink    in_i,
  tccl_out_if.source out_o
);
  import tccl_pkg::*;

  logic    s1_valid_q;
  item_t   s1_item_q;
  logic    out_valid_q;
  result_t out_res_q;
  result_t step_res;
  logic    out_free;
  logic    s1_fire;
  logic    in_fire;

  assign out_free = !out_valid_q || out_o.ready;
  assign s1_fire  = s1_valid_q && out_free;
  assign in_i.ready = !s1_valid_q || out_free;
  assign in_fire  = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_fire) begin
        s1_valid_q <= 1'b1;
      end else if (s1_fire) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_item_q.cmd       <= in_i.cmd;
      s1_item_q.key_code  <= in_i.key_code;
      s1_item_q.is_repeat <= in_i.is_repeat;
    end
    if (s1_fire) begin
      out_res_q <= step_res;
    end
  end

  tccl_engine #(
    .CODE_DIGITS(CODE_DIGITS)
  ) u_engine (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (s1_fire),
    .item_i  (s1_item_q),
    .result_o(step_res)
  );

  assign out_o.valid          = out_valid_q;
  assign out_o.event_res      = out_res_q.event_res;
  assign out_o.mode           = out_res_q.mode;
  assign out_o.digits_entered = out_res_q.digits_entered;

  a_step_fills_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_fire |=> out_valid_q)
    else $error("step result did not reach the result register");

  a_ready_when_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_q |-> in_i.ready)
    else $error("input stalled while the result register was empty");

  a_unlock_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_res_q.event_res == EV_UNLOCKED) |->
      (out_res_q.mode == MODE_UNLOCKED && out_res_q.digits_entered == 3'd0))
    else $error("unlock result without unlocked mode and cleared count");

  a_save_locks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_res_q.event_res == EV_SAVED) |->
      (out_res_q.mode == MODE_LOCKED && out_res_q.digits_entered == 3'd0))
    else $error("saved code without entering the locked mode");

endmodule

FILE: rtl/tccl_engine.sv
// Lock state, digit buffers and the combinational step logic for one item.
module tccl_engine #(
  parameter int unsigned CODE_DIGITS = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  tccl_pkg::item_t   item_i,
  output tccl_pkg::result_t result_o
);
  import tccl_pkg::*;

  localparam int unsigned CntW = $clog2(CODE_DIGITS + 1);
  localparam int unsigned IdxW = (CODE_DIGITS > 1) ? $clog2(CODE_DIGITS) : 1;
  localparam logic [CntW-1:0] CntFull = CntW'(CODE_DIGITS);
  localparam logic [CntW-1:0] CntLast = CntW'(CODE_DIGITS - 1);

  mode_e           mode_q, mode_d;
  logic [CntW-1:0] pad_cnt_q, pad_cnt_d;
  logic [CntW-1:0] remote_cnt_q, remote_cnt_d;
  digit_t          pad_q    [CODE_DIGITS];
  digit_t          pad_d    [CODE_DIGITS];
  digit_t          saved_q  [CODE_DIGITS];
  digit_t          saved_d  [CODE_DIGITS];
  digit_t          remote_q [CODE_DIGITS];
  digit_t          remote_d [CODE_DIGITS];

  lookup_t         lut;
  logic            code_match;
  event_e          ev;
  logic [CntW-1:0] cnt_out;

  assign lut = remote_lookup(item_i.key_code);

  // Compare the remote buffer, with the incoming digit in its last slot, to the code.
  always_comb begin
    code_match = 1'b1;
    for (int i = 0; i < CODE_DIGITS; i++) begin
      if (IdxW'(i) == remote_cnt_q[IdxW-1:0]) begin
        if (lut.digit != saved_q[i]) code_match = 1'b0;
      end else if (remote_q[i] != saved_q[i]) begin
        code_match = 1'b0;
      end
    end
  end

  always_comb begin
    mode_d       = mode_q;
    pad_cnt_d    = pad_cnt_q;
    remote_cnt_d = remote_cnt_q;
    pad_d        = pad_q;
    saved_d      = saved_q;
    remote_d     = remote_q;
    ev           = EV_NONE;

    if (!item_i.cmd) begin
      if (item_i.key_code == KEY_NONE) begin
        ev = EV_NONE;
      end else if (mode_q == MODE_LOCKED) begin
        ev = EV_LOCKED_IGN;
      end else if (item_i.key_code == KEY_STAR) begin
        pad_cnt_d = '0;
        ev        = EV_CLEARED;
      end else if (item_i.key_code == KEY_HASH) begin
        if (pad_cnt_q == CntFull) begin
          saved_d      = pad_q;
          mode_d       = MODE_LOCKED;
          pad_cnt_d    = '0;
          remote_cnt_d = '0;
          ev           = EV_SAVED;
        end else begin
          ev = EV_TOO_FEW;
        end
      end else if (item_i.key_code >= KEY_ZERO && item_i.key_code <= KEY_NINE) begin
        if (pad_cnt_q < CntFull) begin
          pad_d[pad_cnt_q[IdxW-1:0]] = item_i.key_code[3:0];
          pad_cnt_d                  = pad_cnt_q + 1'b1;
          ev                         = EV_DIGIT;
        end else begin
          ev = EV_FULL;
        end
      end
      cnt_out = pad_cnt_d;
    end else begin
      if (item_i.is_repeat) begin
        ev = EV_REPEAT;
      end else if (mode_q != MODE_LOCKED) begin
        ev = EV_NONE;
      end else if (!lut.hit) begin
        ev = EV_UNKNOWN_IR;
      end else if (remote_cnt_q >= CntLast) begin
        // The remote count is cleared on entry to the locked mode and after
        // every compare, so here this digit completes the buffer.
        if (code_match) begin
          mode_d       = MODE_UNLOCKED;
          pad_cnt_d    = '0;
          remote_cnt_d = '0;
          ev           = EV_UNLOCKED;
        end else begin
          remote_cnt_d = '0;
          ev           = EV_WRONG;
        end
      end else begin
        remote_d[remote_cnt_q[IdxW-1:0]] = lut.digit;
        remote_cnt_d                     = remote_cnt_q + 1'b1;
        ev                               = EV_DIGIT;
      end
      cnt_out = remote_cnt_d;
    end
  end

  always_comb begin
    result_o.event_res      = ev;
    result_o.mode           = mode_d;
    result_o.digits_entered = 3'(cnt_out);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q       <= MODE_WAITING;
      pad_cnt_q    <= '0;
      remote_cnt_q <= '0;
    end else if (step_i) begin
      mode_q       <= mode_d;
      pad_cnt_q    <= pad_cnt_d;
      remote_cnt_q <= remote_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_i) begin
      pad_q    <= pad_d;
      saved_q  <= saved_d;
      remote_q <= remote_d;
    end
  end

endmodule
